// ===== hdl/ats_pkg.sv =====
`timescale 1ns / 1ps

package ats_pkg;

	// Timing base of the tick items, in milliseconds.
	localparam int TICK_PERIOD_MS = 50;

	localparam int POS_W      = 10;
	localparam int MUTE_W     = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Command queue between the front and the back end.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Mute seconds to ticks: value*1000/T = value*Q + (value*R)/T.
	// The remainder part is divided by a reciprocal that is exact below 2^24.
	localparam int MUTE_Q      = 1000 / TICK_PERIOD_MS;
	localparam int MUTE_R      = 1000 % TICK_PERIOD_MS;
	localparam int MUTE_PQ_W   = 23;
	localparam int MUTE_PR_W   = 24;
	localparam int RECIP_W     = 30;
	localparam int RECIP_SHIFT = 32;
	localparam logic [63:0] MUTE_RECIP = (64'd1 << RECIP_SHIFT) / TICK_PERIOD_MS + 64'd1;
	localparam logic [MUTE_W-1:0] MUTE_MAX = '1;

	// Configuration reset values.
	localparam logic [5:0] BASE_GAIN_RST = 6'd30;
	localparam logic [6:0] HIGH_OFF_RST  = 7'(-20);
	localparam logic [7:0] GAIN_BASE     = 8'd128;

	typedef enum logic [2:0] {
		OP_TICK         = 3'd0,
		OP_PLAY_HIGH    = 3'd1,
		OP_PLAY_MEDIUM  = 3'd2,
		OP_PLAY_LOW     = 3'd3,
		OP_PLAY_STARTUP = 3'd4,
		OP_STOP         = 3'd5,
		OP_MUTE         = 3'd6,
		OP_TEST         = 3'd7
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_GAIN   = 2'd0,
		REG_HIGH_OFFSET = 2'd1
	} cfg_reg_t;

	typedef enum logic [5:0] {
		PS_IDLE    = 6'b000001,
		PS_HIGH    = 6'b000010,
		PS_MEDIUM  = 6'b000100,
		PS_LOW     = 6'b001000,
		PS_STARTUP = 6'b010000,
		PS_MUTE    = 6'b100000
	} play_state_t;

	// External play state codes.
	localparam logic [2:0] CODE_IDLE    = 3'd0;
	localparam logic [2:0] CODE_HIGH    = 3'd1;
	localparam logic [2:0] CODE_MEDIUM  = 3'd2;
	localparam logic [2:0] CODE_LOW     = 3'd3;
	localparam logic [2:0] CODE_STARTUP = 3'd4;
	localparam logic [2:0] CODE_MUTE    = 3'd5;

	// Tone codes.
	localparam logic [1:0] TONE_NONE   = 2'd0;
	localparam logic [1:0] TONE_HIGH   = 2'd1;
	localparam logic [1:0] TONE_MEDIUM = 2'd2;
	localparam logic [1:0] TONE_LOW    = 2'd3;

	// One queued command, already decoded by the front end.
	typedef struct packed {
		op_t               op;
		logic [7:0]        gain_code;
		logic [MUTE_W-1:0] mute_ticks;
	} q_entry_t;

	// Tick position of a burst that starts at the given time.
	function automatic int pos_of(input int ms);
		return ms / TICK_PERIOD_MS - 1;
	endfunction

	localparam int HIGH_MARKS [10] = '{0, pos_of(250), pos_of(500), pos_of(1000),
		pos_of(1250), pos_of(2000), pos_of(2250), pos_of(2500), pos_of(3000),
		pos_of(3250)};
	localparam int MEDIUM_MARKS [3] = '{0, pos_of(400), pos_of(800)};
	localparam int LOW_MARKS [2] = '{0, pos_of(450)};
	localparam int STARTUP_MARKS [13] = '{0, pos_of(250), pos_of(500), pos_of(750),
		pos_of(1000), pos_of(1250), pos_of(1500), pos_of(1750), pos_of(2000),
		pos_of(2250), pos_of(2500), pos_of(2750), pos_of(3000)};

	localparam int HIGH_GATE   = pos_of(1250) + pos_of(500);
	localparam int MEDIUM_GATE = pos_of(800) + pos_of(500);
	localparam int LOW_GATE    = pos_of(450) + pos_of(500);

	localparam int HIGH_WRAP    = pos_of(10000);
	localparam int MEDIUM_WRAP  = pos_of(25000);
	localparam int LOW_WRAP     = pos_of(30000);
	localparam int STARTUP_WRAP = pos_of(3000);

	// True when a burst of the pattern starts at this position.
	function automatic logic mark_hit(input play_state_t ps, input logic [POS_W-1:0] pos);
		logic hit;
		hit = 1'b0;
		unique case (ps)
			PS_HIGH: for (int i = 0; i < 10; i++) hit |= (HIGH_MARKS[i] == int'(pos));
			PS_MEDIUM: for (int i = 0; i < 3; i++) hit |= (MEDIUM_MARKS[i] == int'(pos));
			PS_LOW: for (int i = 0; i < 2; i++) hit |= (LOW_MARKS[i] == int'(pos));
			PS_STARTUP: for (int i = 0; i < 13; i++) hit |= (STARTUP_MARKS[i] == int'(pos));
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// True once the burst group is over and the pattern may yield.
	function automatic logic gate_open(input play_state_t ps, input logic [POS_W-1:0] pos);
		logic open;
		unique case (ps)
			PS_HIGH: open = int'(pos) > HIGH_GATE;
			PS_MEDIUM: open = int'(pos) > MEDIUM_GATE;
			PS_LOW: open = int'(pos) > LOW_GATE;
			default: open = 1'b1;
		endcase
		return open;
	endfunction

	function automatic int wrap_limit(input play_state_t ps);
		int lim;
		unique case (ps)
			PS_HIGH: lim = HIGH_WRAP;
			PS_MEDIUM: lim = MEDIUM_WRAP;
			PS_LOW: lim = LOW_WRAP;
			default: lim = STARTUP_WRAP;
		endcase
		return lim;
	endfunction

	function automatic logic [1:0] burst_tone(input play_state_t ps);
		logic [1:0] t;
		unique case (ps)
			PS_HIGH, PS_STARTUP: t = TONE_HIGH;
			PS_MEDIUM: t = TONE_MEDIUM;
			PS_LOW: t = TONE_LOW;
			default: t = TONE_NONE;
		endcase
		return t;
	endfunction

	function automatic logic [2:0] state_code(input play_state_t ps);
		logic [2:0] c;
		unique case (ps)
			PS_IDLE: c = CODE_IDLE;
			PS_HIGH: c = CODE_HIGH;
			PS_MEDIUM: c = CODE_MEDIUM;
			PS_LOW: c = CODE_LOW;
			PS_STARTUP: c = CODE_STARTUP;
			PS_MUTE: c = CODE_MUTE;
			default: c = CODE_IDLE;
		endcase
		return c;
	endfunction

	// Pattern requested by a play or test command.
	function automatic play_state_t op_state(input op_t op);
		play_state_t ps;
		unique case (op) inside
			OP_PLAY_HIGH: ps = PS_HIGH;
			OP_PLAY_MEDIUM: ps = PS_MEDIUM;
			OP_PLAY_STARTUP: ps = PS_STARTUP;
			default: ps = PS_LOW;
		endcase
		return ps;
	endfunction

endpackage

// ===== hdl/ats_ifs.sv =====
`timescale 1ns / 1ps

// Command channel: one tick or command per transaction.
interface ats_cmd_if ();
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [15:0] value;

	modport source (output valid, op, value, input ready);
	modport sink (input valid, op, value, output ready);
endinterface

// Result channel: one result per command transaction.
interface ats_result_if ();
	logic       valid;
	logic       ready;
	logic [1:0] tone;
	logic       gain_write;
	logic [7:0] gain_code;
	logic       mute_over;
	logic [2:0] play_state;

	modport source (output valid, tone, gain_write, gain_code, mute_over, play_state,
		input ready);
	modport sink (input valid, tone, gain_write, gain_code, mute_over, play_state,
		output ready);
endinterface

// Configuration write channel.
interface ats_cfg_if import ats_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/ats_front.sv =====
`timescale 1ns / 1ps

module ats_front import ats_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	ats_cmd_if.sink  cmd,
	ats_cfg_if.sink  cfg,
	output logic     push_valid,
	input  logic     push_ready,
	output q_entry_t push_entry
);

	logic [5:0] base_gain_q;
	logic [6:0] high_off_q;

	logic                 valid_s1;
	op_t                  op_s1;
	logic [7:0]           gain_s1;
	logic [MUTE_PQ_W-1:0] pq_s1;
	logic [MUTE_PR_W-1:0] pr_s1;

	op_t        op_in;
	logic [3:0] level;
	logic [7:0] gain_in;
	logic       accept;

	logic [MUTE_PR_W+RECIP_W-1:0] prod;
	logic [MUTE_PR_W+RECIP_W-RECIP_SHIFT-1:0] frac;
	logic [MUTE_PR_W-1:0] ticks;

	// Configuration registers take every write transaction.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_gain_q <= BASE_GAIN_RST;
			high_off_q  <= HIGH_OFF_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_BASE_GAIN: base_gain_q <= cfg.data[5:0];
				REG_HIGH_OFFSET: high_off_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Speaker gain: out-of-range levels count as level 1.
	assign op_in = op_t'(cmd.op);

	always_comb begin
		level = (cmd.value == 16'd0 || cmd.value > 16'd10) ? 4'd1 : cmd.value[3:0];
		gain_in = GAIN_BASE + {2'b00, base_gain_q} + {2'b00, 4'd10 - level, 2'b00};
		if (op_in == OP_PLAY_HIGH) begin
			gain_in = gain_in + {high_off_q[6], high_off_q};
		end
	end

	// Stage 1 holds one decoded item until the queue takes it.
	assign cmd.ready = !valid_s1 || push_ready;
	assign accept    = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_in;
			gain_s1 <= gain_in;
			pq_s1   <= MUTE_PQ_W'(cmd.value) * MUTE_PQ_W'(MUTE_Q);
			pr_s1   <= MUTE_PR_W'(cmd.value) * MUTE_PR_W'(MUTE_R);
		end
	end

	// Mute ticks: whole part plus the remainder part divided by reciprocal.
	assign prod  = (MUTE_PR_W + RECIP_W)'(pr_s1) * (MUTE_PR_W + RECIP_W)'(MUTE_RECIP[RECIP_W-1:0]);
	assign frac  = prod[MUTE_PR_W+RECIP_W-1:RECIP_SHIFT];
	assign ticks = MUTE_PR_W'(pq_s1) + MUTE_PR_W'(frac);

	always_comb begin
		push_entry.op         = op_s1;
		push_entry.gain_code  = gain_s1;
		push_entry.mute_ticks = (ticks > MUTE_PR_W'(MUTE_MAX)) ? MUTE_MAX : ticks[MUTE_W-1:0];
	end

	assign push_valid = valid_s1;

endmodule

// ===== hdl/ats_queue.sv =====
`timescale 1ns / 1ps

module ats_queue import ats_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  q_entry_t push_entry,
	output logic     pop_valid,
	input  logic     pop,
	output q_entry_t pop_entry
);

	q_entry_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop_entry  = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");

endmodule

// ===== hdl/ats_back.sv =====
`timescale 1ns / 1ps

module ats_back import ats_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop,
	input  q_entry_t    pop_entry,
	ats_result_if.source result
);

	play_state_t       cur_q, pend_q, saved_q;
	logic [POS_W-1:0]  pos_q;
	logic              running_q;
	logic [MUTE_W-1:0] mute_rem_q;
	logic              armed_q;

	play_state_t       cur_n, pend_n, saved_n;
	logic [POS_W-1:0]  pos_n, pos_inc;
	logic              running_n;
	logic [MUTE_W-1:0] mute_rem_n;
	logic              armed_n;

	logic [1:0] tone_n;
	logic       gw_n;
	logic [7:0] gain_n;
	logic       mo_n;

	logic       res_valid_q;
	logic [1:0] tone_q;
	logic       gw_q;
	logic [7:0] gain_q;
	logic       mo_q;
	logic [2:0] ps_q;

	assign pop = pop_valid && (!res_valid_q || result.ready);
	assign pos_inc = pos_q + 1'b1;

	// Next state for the command at the head of the queue.
	always_comb begin
		cur_n      = cur_q;
		pend_n     = pend_q;
		saved_n    = saved_q;
		pos_n      = pos_q;
		running_n  = running_q;
		mute_rem_n = mute_rem_q;
		armed_n    = armed_q;
		tone_n     = TONE_NONE;
		gw_n       = 1'b0;
		gain_n     = 8'd0;
		mo_n       = 1'b0;

		unique case (pop_entry.op) inside
			OP_TICK: begin
				// Mute expiry comes before the pattern step.
				if (armed_q) begin
					if (mute_rem_q <= MUTE_W'(1)) begin
						pend_n     = saved_q;
						armed_n    = 1'b0;
						mute_rem_n = '0;
						mo_n       = 1'b1;
					end else begin
						mute_rem_n = mute_rem_q - 1'b1;
					end
				end
				if (running_q) begin
					unique case (cur_q) inside
						PS_IDLE: begin
							if (cur_q != pend_n) begin
								cur_n = pend_n;
							end else begin
								running_n = 1'b0;
							end
							pos_n = '0;
						end
						PS_MUTE: begin
							if (cur_q != pend_n) begin
								cur_n = pend_n;
							end
						end
						PS_HIGH, PS_MEDIUM, PS_LOW, PS_STARTUP: begin
							if (mark_hit(cur_q, pos_q)) begin
								tone_n = burst_tone(cur_q);
							end
							if (gate_open(cur_q, pos_q) && cur_q != pend_n) begin
								cur_n = pend_n;
								pos_n = '0;
							end else begin
								pos_n = (int'(pos_inc) >= wrap_limit(cur_q)) ? '0 : pos_inc;
							end
						end
						default: ;
					endcase
				end
			end
			OP_PLAY_HIGH, OP_PLAY_MEDIUM, OP_PLAY_LOW, OP_PLAY_STARTUP: begin
				gw_n      = 1'b1;
				gain_n    = pop_entry.gain_code;
				pend_n    = op_state(pop_entry.op);
				running_n = 1'b1;
			end
			OP_STOP: begin
				pend_n = PS_IDLE;
			end
			OP_MUTE: begin
				// Mute is honored only while a pattern plays.
				if (cur_q == PS_HIGH || cur_q == PS_MEDIUM || cur_q == PS_LOW
					|| cur_q == PS_STARTUP) begin
					saved_n    = cur_q;
					pend_n     = PS_MUTE;
					mute_rem_n = pop_entry.mute_ticks;
					armed_n    = 1'b1;
				end
			end
			OP_TEST: begin
				pos_n     = '0;
				gw_n      = 1'b1;
				gain_n    = pop_entry.gain_code;
				pend_n    = PS_LOW;
				running_n = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= PS_IDLE;
			pend_q     <= PS_IDLE;
			saved_q    <= PS_IDLE;
			pos_q      <= '0;
			running_q  <= 1'b0;
			mute_rem_q <= '0;
			armed_q    <= 1'b0;
		end else if (pop) begin
			cur_q      <= cur_n;
			pend_q     <= pend_n;
			saved_q    <= saved_n;
			pos_q      <= pos_n;
			running_q  <= running_n;
			mute_rem_q <= mute_rem_n;
			armed_q    <= armed_n;
		end
	end

	// Output register decouples the result channel from the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tone_q <= tone_n;
			gw_q   <= gw_n;
			gain_q <= gain_n;
			mo_q   <= mo_n;
			ps_q   <= state_code(cur_n);
		end
	end

	assign result.valid      = res_valid_q;
	assign result.tone       = tone_q;
	assign result.gain_write = gw_q;
	assign result.gain_code  = gain_q;
	assign result.mute_over  = mo_q;
	assign result.play_state = ps_q;

	a_saved_playing: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> (saved_q == PS_HIGH || saved_q == PS_MEDIUM || saved_q == PS_LOW
			|| saved_q == PS_STARTUP))
		else $error("mute armed without a saved pattern");

	a_disarmed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> mute_rem_q == '0)
		else $error("mute countdown left over while disarmed");

	a_stopped_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> pos_q == '0)
		else $error("tick position moved while sequencer stopped");

endmodule

// ===== hdl/alarm_tone_sequencer.sv =====
`timescale 1ns / 1ps

// Alarm tone sequencer. Each command transaction is a 50 ms tick or a play,
// stop, mute or test command and yields exactly one result transaction. The
// block takes one transaction per clock cycle when the result side keeps up;
// a result is presented once its command has been registered in the decode
// stage, written to the queue, and taken by the sequencer step, which loads
// the output register. The sequencer step, which updates the pattern, tick
// position and mute countdown together, sets that rate. A two-entry queue
// between the decode stage and the sequencer lets either side stall alone.
// Configuration writes are taken at any time but should only be issued while
// no command is in flight.
module alarm_tone_sequencer import ats_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ats_cmd_if.sink      cmd,
	ats_cfg_if.sink      cfg,
	ats_result_if.source result
);

	logic     push_valid;
	logic     push_ready;
	q_entry_t push_entry;
	logic     pop_valid;
	logic     pop;
	q_entry_t pop_entry;

	ats_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	ats_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_entry  (pop_entry)
	);

	ats_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_entry (pop_entry),
		.result    (result)
	);

endmodule
